// File: hdl/naa_pkg.sv
// Package: types, constants and the tanh table for the neuron aggregate/activate block
`default_nettype none
package naa_pkg;

    localparam int unsigned MAX_INPUTS_DEF = 256;
    localparam int unsigned ACC_W = 48;

    localparam logic [1:0] AGG_SUM = 2'd0;
    localparam logic [1:0] AGG_AVG = 2'd1;
    localparam logic [1:0] AGG_MAX = 2'd2;
    localparam logic [1:0] AGG_MIN = 2'd3;

    localparam logic ACT_TANH = 1'b0;
    localparam logic ACT_RELU = 1'b1;

    localparam logic CFG_AGG = 1'b0;
    localparam logic CFG_ACT = 1'b1;

    typedef struct packed {
        logic signed [15:0] prev_output;
        logic signed [15:0] weight;
        logic               is_last;
    } in_item_t;

    typedef struct packed {
        logic signed [15:0] aggregate;
        logic signed [15:0] activated;
        logic               saturated;
    } out_item_t;

    typedef struct packed {
        logic fold;
        logic finish;
        logic div_start;
        logic div_step;
        logic round_load;
        logic act_load;
        logic out_load;
    } ctl_cmd_t;

    typedef struct packed {
        logic div_done;
    } ctl_sts_t;

    function automatic logic [12:0] tanh_tab(input logic [5:0] k);
        logic [12:0] r;
        begin
            case (k)
                6'd0: r = 13'd0;     6'd1: r = 13'd509;   6'd2: r = 13'd1003;
                6'd3: r = 13'd1468;  6'd4: r = 13'd1893;  6'd5: r = 13'd2272;
                6'd6: r = 13'd2602;  6'd7: r = 13'd2883;  6'd8: r = 13'd3119;
                6'd9: r = 13'd3315;  6'd10: r = 13'd3475; 6'd11: r = 13'd3604;
                6'd12: r = 13'd3707; 6'd13: r = 13'd3790; 6'd14: r = 13'd3856;
                6'd15: r = 13'd3908; 6'd16: r = 13'd3949; 6'd17: r = 13'd3981;
                6'd18: r = 13'd4006; 6'd19: r = 13'd4026; 6'd20: r = 13'd4042;
                6'd21: r = 13'd4053; 6'd22: r = 13'd4063; 6'd23: r = 13'd4070;
                6'd24: r = 13'd4076; 6'd25: r = 13'd4080; 6'd26: r = 13'd4084;
                6'd27: r = 13'd4086; 6'd28: r = 13'd4089; 6'd29: r = 13'd4090;
                6'd30: r = 13'd4091; 6'd31: r = 13'd4092; 6'd32: r = 13'd4093;
                default: r = 13'd4093;
            endcase
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// File: hdl/naa_datapath.sv
// Datapath: multiply, fold, restoring divide, round/clamp, activation, result register
`default_nettype none
module naa_datapath #(
    parameter int unsigned MAX_INPUTS = naa_pkg::MAX_INPUTS_DEF,
    parameter int unsigned CNT_W      = $clog2(MAX_INPUTS + 1)
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  naa_pkg::in_item_t    in_item,
    input  wire [1:0]            agg_mode,
    input  wire                  act_mode,
    input  naa_pkg::ctl_cmd_t    cmd,
    output naa_pkg::ctl_sts_t    sts,
    output naa_pkg::out_item_t   out_item
);
    import naa_pkg::*;

    localparam int unsigned STEP_W = $clog2(ACC_W + 1);

    logic signed [ACC_W-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [31:0]      prod;

    logic [ACC_W-1:0]        quo_reg, quo_next;
    logic [CNT_W:0]          rem_reg, rem_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic                    neg_reg, neg_next;
    logic [CNT_W-1:0]        dvs_reg, dvs_next;
    logic signed [ACC_W-1:0] val_reg, val_next;

    logic signed [15:0]      agg_reg, agg_next;
    logic                    sat_reg, sat_next;
    logic signed [15:0]      act_val;
    logic                    agg_m_reg;

    logic [ACC_W-1:0]        mag;
    logic [CNT_W:0]          trial;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-13:0] q12;

    logic [15:0]             a_abs;
    logic [5:0]              ti;
    logic [12:0]             t0, t1;
    logic [22:0]             lin;
    logic [15:0]             y;

    out_item_t               out_reg;

    assign prod = in_item.prev_output * in_item.weight;

    always_comb
    begin
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        if (cmd.fold && (cnt_reg < CNT_W'(MAX_INPUTS)))
        begin
            cnt_next = cnt_reg + 1'b1;
            case (agg_mode)
                AGG_SUM, AGG_AVG: acc_next = acc_reg + ACC_W'(prod);
                AGG_MAX: if (ACC_W'(prod) > acc_reg) acc_next = ACC_W'(prod);
                default: if (ACC_W'(prod) < acc_reg) acc_next = ACC_W'(prod);
            endcase
        end
        if (cmd.finish)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    // restoring divide of |acc| by count, one bit per cycle
    assign mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
    assign trial = {rem_reg[CNT_W-1:0], quo_reg[ACC_W-1]};

    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        step_next = step_reg;
        neg_next  = neg_reg;
        dvs_next  = dvs_reg;
        val_next  = val_reg;
        if (cmd.div_start)
        begin
            neg_next  = acc_reg[ACC_W-1];
            dvs_next  = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;
            quo_next  = mag;
            rem_next  = '0;
            step_next = STEP_W'(ACC_W);
            val_next  = acc_reg;
        end
        else if (cmd.div_step && (step_reg != '0))
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next = trial - {1'b0, dvs_reg};
                quo_next = {quo_reg[ACC_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[ACC_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
        end
    end

    assign sts.div_done = (step_reg == '0);

    always_comb
    begin
        rnd      = ((agg_m_reg ? (neg_reg ? -$signed(quo_reg) : $signed(quo_reg)) : val_reg))
                   + ACC_W'(2048);
        q12      = rnd[ACC_W-1:12];
        agg_next = agg_reg;
        sat_next = sat_reg;
        if (cmd.round_load)
        begin
            if (q12 > (ACC_W-12)'(32767))
            begin
                agg_next = 16'sh7FFF;
                sat_next = 1'b1;
            end
            else if (q12 < -(ACC_W-12)'(32768))
            begin
                agg_next = -16'sh8000;
                sat_next = 1'b1;
            end
            else
            begin
                agg_next = q12[15:0];
                sat_next = 1'b0;
            end
        end
    end

    always_comb
    begin
        a_abs = agg_reg[15] ? 16'(-agg_reg) : 16'(agg_reg);
        ti    = 6'(a_abs[15:9]);
        t0    = tanh_tab(ti);
        t1    = tanh_tab(ti + 6'd1);
        if (a_abs < 16'd16384)
        begin
            lin = 23'((t1 - t0) * a_abs[8:0]) + 23'd256;
            y   = 16'(t0) + 16'(lin[22:9]);
        end
        else
        begin
            lin = 23'(3 * (a_abs - 16'd16384)) + 23'd8192;
            y   = 16'd4093 + 16'(lin[22:14]);
        end
        if (act_mode == ACT_RELU)
            act_val = agg_reg[15] ? 16'sd0 : agg_reg;
        else
            act_val = agg_reg[15] ? -$signed(y) : $signed(y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            cnt_reg   <= '0;
            step_reg  <= '0;
            agg_m_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            step_reg <= step_next;
            if (cmd.div_start)
                agg_m_reg <= (agg_mode == AGG_AVG);
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
        dvs_reg <= dvs_next;
        val_reg <= val_next;
        agg_reg <= agg_next;
        sat_reg <= sat_next;
        if (cmd.out_load)
        begin
            out_reg.aggregate <= agg_reg;
            out_reg.activated <= act_val;
            out_reg.saturated <= sat_reg;
        end
    end

    assign out_item = out_reg;

endmodule
`default_nettype wire

// File: hdl/naa_ctrl.sv
// Controller: item handshake, finish sequence and output valid
`default_nettype none
module naa_ctrl (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire                in_last,
    output logic               out_valid,
    input  wire                out_ready,
    input  naa_pkg::ctl_sts_t  sts,
    output naa_pkg::ctl_cmd_t  cmd
);
    import naa_pkg::*;

    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ACT   = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic       acc_in;

    assign in_ready  = (state_reg == ST_RUN);
    assign acc_in    = in_valid && in_ready;
    assign out_valid = ov_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next    = ov_reg && !out_ready;
        cmd        = '0;
        case (state_reg)
            ST_RUN:
            begin
                cmd.fold = acc_in;
                if (acc_in && in_last)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                begin
                    cmd.round_load = 1'b1;
                    cmd.finish     = 1'b1;
                    state_next     = ST_ACT;
                end
            end
            ST_ACT:
            begin
                if (!ov_reg || out_ready)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                cmd.out_load = 1'b1;
                ov_next      = 1'b1;
                state_next   = ST_RUN;
            end
            default: state_next = ST_RUN;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

endmodule
`default_nettype wire

// File: hdl/neuron_aggregate_activate_top.sv
// Top level: neuron multiply-aggregate with tanh/ReLU activation
//  channel | signals                               | direction
//  in      | in_valid, in_ready, in_data          | item in
//  out     | out_valid, out_ready, out_data       | result out
//  cfg     | cfg_valid, cfg_ready, cfg_index/data | register write
// Items not marked last are taken one per cycle; a last item holds
// in_ready low through the one-bit-per-cycle 48-bit divide.
// Reset clears the accumulator, count, modes and output valid.
// A result waiting on out_ready holds the next last item before its output.
// Register writes wait while a vector finishes or an item is offered.
`default_nettype none
module neuron_aggregate_activate_top #(
    parameter int unsigned MAX_INPUTS = naa_pkg::MAX_INPUTS_DEF
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  naa_pkg::in_item_t   in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output naa_pkg::out_item_t  out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire                 cfg_index,
    input  wire [1:0]           cfg_data
);
    import naa_pkg::*;

    logic [1:0] agg_mode_reg;
    logic       act_mode_reg;
    ctl_cmd_t   cmd;
    ctl_sts_t   sts;

    assign cfg_ready = in_ready && !in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            agg_mode_reg <= AGG_SUM;
            act_mode_reg <= ACT_TANH;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_AGG)
                agg_mode_reg <= cfg_data;
            else
                act_mode_reg <= cfg_data[0];
        end
    end

    naa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_last   (in_data.is_last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    naa_datapath #(.MAX_INPUTS(MAX_INPUTS)) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_data),
        .agg_mode (agg_mode_reg),
        .act_mode (act_mode_reg),
        .cmd      (cmd),
        .sts      (sts),
        .out_item (out_data)
    );

    a_fold_only_run: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fold |-> in_ready) else $error("fold outside run");
    a_load_once: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid) else $error("result not shown");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_data.is_last) |=> !in_ready)
        else $error("accepted during finish");

endmodule
`default_nettype wire

// File: verif/neuron_aggregate_activate_top_tb.sv
// Testbench for the neuron multiply-aggregate block with tanh/ReLU activation
`timescale 1ns / 1ps
`default_nettype none
module neuron_aggregate_activate_top_tb;
    import naa_pkg::*;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_item_t in_data;
    logic out_valid;
    logic out_ready;
    out_item_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic cfg_index;
    logic [1:0] cfg_data;

    neuron_aggregate_activate_top u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    localparam int NEURON_FANIN = 256;

    logic [1:0] agg_mode;
    logic act_mode;
    logic signed [47:0] mac_acc;
    int unsigned mac_count;
    out_item_t neuron_results[$];
    int errors;
    int results_seen;
    int vectors_sent;
    int items_sent;
    int send_idle_pct;
    int recv_idle_pct;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic signed [15:0] tanh_pw(input logic signed [15:0] x);
        int a;
        int y;
        int i;
        int lo;
        int hi;
        a = (x < 0) ? -int'(x) : int'(x);
        if (a < 16384)
        begin
            i = a >> 9;
            lo = tanh_tab(i[5:0]);
            hi = tanh_tab(i[5:0] + 6'd1);
            y = lo + (((hi - lo) * (a & 511) + 256) >>> 9);
        end
        else
        begin
            lo = tanh_tab(6'd32);
            y = lo + (((4096 - lo) * (a - 16384) + 8192) >>> 14);
        end
        return (x < 0) ? 16'(-y) : 16'(y);
    endfunction

    task automatic predict_neuron(input in_item_t it);
        longint p;
        longint v;
        longint agg;
        out_item_t r;
        p = longint'(it.prev_output) * longint'(it.weight);
        if (mac_count < NEURON_FANIN)
        begin
            case (agg_mode)
                AGG_SUM, AGG_AVG: mac_acc = mac_acc + 48'(p);
                AGG_MAX: if (p > longint'(mac_acc)) mac_acc = 48'(p);
                default: if (p < longint'(mac_acc)) mac_acc = 48'(p);
            endcase
            mac_count++;
        end
        if (!it.is_last)
            return;
        v = longint'(mac_acc);
        if (agg_mode == AGG_AVG)
            v = v / longint'((mac_count == 0) ? 1 : mac_count);
        agg = (v + 2048) >>> 12;
        r.saturated = 1'b0;
        if (agg > 32767)
        begin
            agg = 32767;
            r.saturated = 1'b1;
        end
        else if (agg < -32768)
        begin
            agg = -32768;
            r.saturated = 1'b1;
        end
        r.aggregate = 16'(agg);
        if (act_mode == ACT_TANH)
            r.activated = tanh_pw(r.aggregate);
        else
            r.activated = (agg > 0) ? 16'(agg) : 16'sd0;
        neuron_results.push_back(r);
        mac_acc = '0;
        mac_count = 0;
    endtask

    task automatic send_item(input logic signed [15:0] po, input logic signed [15:0] w,
                             input logic last);
        in_item_t it;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.prev_output = po;
        it.weight = w;
        it.is_last = last;
        in_valid <= 1'b1;
        in_data <= it;
        do
            @(posedge clk);
        while (!in_ready);
        predict_neuron(it);
        items_sent++;
        if (last)
            vectors_sent++;
    endtask

    task automatic drain_results();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (neuron_results.size() != 0 && guard < 200000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (80) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [1:0] val);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_AGG)
            agg_mode = val;
        else
            act_mode = val[0];
    endtask

    function automatic logic signed [15:0] rand_val();
        case ($urandom_range(5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(8191));
            3: return -16'($urandom_range(8191));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len);
        for (int k = 0; k < len; k++)
            send_item(rand_val(), rand_val(), k == len - 1);
    endtask

    task automatic test_directed();
        logic [1:0] m;
        m = AGG_SUM;
        for (int a = 0; a < 2; a++)
        begin
            write_reg(CFG_ACT, 2'(a));
            for (int g = 0; g < 4; g++)
            begin
                m = 2'(g);
                write_reg(CFG_AGG, m);
                send_item(16'sh7FFF, 16'sh7FFF, 1'b0);
                send_item(16'sh8000, 16'sh7FFF, 1'b1);
            end
        end
        write_reg(CFG_AGG, AGG_SUM);
        send_item(16'sh8000, 16'sh8000, 1'b1);
        send_item(16'sh1000, 16'sh0800, 1'b1);
        send_item(16'sh1000, 16'shF800, 1'b1);
        write_reg(CFG_ACT, {1'b0, ACT_TANH});
        send_item(16'sh2000, 16'sh2000, 1'b1);
        send_item(16'shE000, 16'sh2000, 1'b1);
        send_item(16'sh1000, 16'sh1000, 1'b0);
        write_reg(CFG_AGG, AGG_AVG);
        send_item(16'sh0400, 16'sh1000, 1'b1);
    endtask

    task automatic test_overflow_count();
        write_reg(CFG_AGG, AGG_AVG);
        for (int k = 0; k < NEURON_FANIN + 4; k++)
            send_item(16'sh0100 + 16'(k), 16'sh1000, k == NEURON_FANIN + 3);
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int len;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(9) == 0)
                write_reg(CFG_AGG, 2'($urandom_range(3)));
            if ($urandom_range(9) == 0)
                write_reg(CFG_ACT, 2'($urandom_range(1)));
            len = ($urandom_range(19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
            send_vector(len);
            sent += len;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (neuron_results.size() == 0)
            begin
                $error("unexpected result aggregate=%0d", out_data.aggregate);
                errors++;
            end
            else
            begin
                out_item_t e;
                e = neuron_results.pop_front();
                if (out_data.aggregate !== e.aggregate)
                begin
                    $error("aggregate exp %0d got %0d", e.aggregate, out_data.aggregate);
                    errors++;
                end
                if (out_data.activated !== e.activated)
                begin
                    $error("activated exp %0d got %0d", e.activated, out_data.activated);
                    errors++;
                end
                if (out_data.saturated !== e.saturated)
                begin
                    $error("saturated exp %0d got %0d", e.saturated, out_data.saturated);
                    errors++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        #400ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_AGG;
        cfg_data = AGG_SUM;
        agg_mode = AGG_SUM;
        act_mode = ACT_TANH;
        mac_acc = '0;
        mac_count = 0;
        errors = 0;
        results_seen = 0;
        vectors_sent = 0;
        items_sent = 0;
        send_idle_pct = 35;
        recv_idle_pct = 84;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_overflow_count();
        test_random(200);
        send_idle_pct = 84;
        recv_idle_pct = 35;
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        drain_results();
        if (neuron_results.size() != 0)
        begin
            $error("%0d results never arrived", neuron_results.size());
            errors++;
        end
        $display("Covered %0d items in %0d vectors, %0d results checked,", items_sent,
                 vectors_sent, results_seen);
        $display("all four aggregations, both activations, saturation and fan-in overflow.");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire
